/* design/whp_pkg.sv */
// Shared types and constants for the RIFF/WAVE header parser.
// No dependencies; used by whp_front, whp_back and wav_header_parser.
package whp_pkg;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [31:0] ID_RIFF  = 32'h5249_4646;  // "RIFF"
   localparam logic [31:0] ID_WAVE  = 32'h5741_5645;  // "WAVE"
   localparam logic [31:0] ID_FMT   = 32'h666D_7420;  // "fmt "
   localparam logic [31:0] ID_DATA  = 32'h6461_7461;  // "data"
   localparam logic [31:0] FMT_SIZE = 32'd16;

   typedef enum logic [2:0] {
      PH_RIFF    = 3'd0,
      PH_FMT     = 3'd1,
      PH_SEARCH  = 3'd2,
      PH_SKIP    = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_FAILED  = 3'd5
   } phase_type;

   typedef enum logic [2:0] {
      ST_TAKEN   = 3'd0,
      ST_DONE    = 3'd1,
      ST_FAIL    = 3'd2,
      ST_PAYLOAD = 3'd3,
      ST_IGNORED = 3'd4
   } status_type;

   typedef enum logic {
      KIND_BYTE    = 1'b0,
      KIND_RESTART = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
   } entry_type;

   // queue head as seen by the back end
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } head_type;

endpackage

/* design/whp_front.sv */
// Front end: accepts requests, classifies them and holds them in a short queue.
// Depends on whp_pkg.
module whp_front #(
   parameter int Depth = whp_pkg::QUEUE_DEPTH
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic              req_action,
   input  logic [7:0]        req_stream_byte,
   output whp_pkg::head_type head,
   input  logic              pop
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

   whp_pkg::entry_type entries_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff, count_in;
   logic               push;
   logic               do_pop;
   whp_pkg::entry_type new_entry;

   assign req_stall = (count_ff == FullCnt);
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   // restart requests drop the byte so the back end sees a clean entry
   always_comb begin
      new_entry.kind = req_action ? whp_pkg::KIND_RESTART : whp_pkg::KIND_BYTE;
      new_entry.data = req_action ? 8'd0 : req_stream_byte;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !push) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= new_entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = entries_ff[rd_ptr_ff];

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FullCnt)
      else $error("queue count over depth");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !do_pop |=> count_ff == $past(count_ff) + CntW'(1))
      else $error("push without pop did not grow the queue");

   a_empty_no_head: assert property (@(posedge clock) disable iff (reset)
      count_ff == '0 |-> !head.valid && !do_pop)
      else $error("empty queue presents or pops an entry");
`endif

endmodule

/* design/whp_back.sv */
// Back end: the header parse state machine and the registered result stage.
// Depends on whp_pkg; fed by whp_front.
module whp_back (
   input  logic              clock,
   input  logic              reset,
   input  whp_pkg::head_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [2:0]        rsp_status,
   output logic [7:0]        rsp_payload_byte,
   output logic [15:0]       rsp_channel_count,
   output logic [15:0]       rsp_sample_width,
   output logic [31:0]       rsp_rate_hz
);

   whp_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [31:0] id_ff, id_in;
   logic [31:0] size_ff, size_in;
   logic [31:0] skip_ff, skip_in;
   logic [15:0] chan_ff, chan_in;
   logic [15:0] width_ff, width_in;
   logic [31:0] rate_ff, rate_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  status_ff;
   logic [7:0]  pay_ff;
   logic [15:0] out_chan_ff;
   logic [15:0] out_width_ff;
   logic [31:0] out_rate_ff;

   whp_pkg::status_type status_in;
   logic [7:0]  pay_in;
   logic        take;
   logic [7:0]  b;
   logic        fmt_ok;

   assign take = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = take;
   assign b    = head.entry.data;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      id_in     = id_ff;
      size_in   = size_ff;
      skip_in   = skip_ff;
      chan_in   = chan_ff;
      width_in  = width_ff;
      rate_in   = rate_ff;
      status_in = whp_pkg::ST_TAKEN;
      pay_in    = 8'd0;
      fmt_ok    = 1'b0;

      if (head.entry.kind == whp_pkg::KIND_RESTART) begin
         phase_in  = whp_pkg::PH_RIFF;
         pos_in    = '0;
         id_in     = '0;
         size_in   = '0;
         skip_in   = '0;
         chan_in   = '0;
         width_in  = '0;
         rate_in   = '0;
         status_in = whp_pkg::ST_IGNORED;
      end else begin
         case (phase_ff)
            whp_pkg::PH_RIFF: begin
               if (pos_ff < 5'd4) begin
                  id_in = {id_ff[23:0], b};
               end else if (pos_ff >= 5'd8) begin
                  size_in = {size_ff[23:0], b};
               end
               if (pos_ff >= 5'd11) begin
                  pos_in = '0;
                  if (id_in != whp_pkg::ID_RIFF || size_in != whp_pkg::ID_WAVE) begin
                     phase_in  = whp_pkg::PH_FAILED;
                     status_in = whp_pkg::ST_FAIL;
                  end else begin
                     phase_in = whp_pkg::PH_FMT;
                  end
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
            whp_pkg::PH_FMT: begin
               if (pos_ff < 5'd4) begin
                  id_in = {id_ff[23:0], b};
               end else if (pos_ff < 5'd8) begin
                  size_in = {b, size_ff[31:8]};
               end else if (pos_ff == 5'd10) begin
                  chan_in = {8'd0, b};
               end else if (pos_ff == 5'd11) begin
                  chan_in = {b, chan_ff[7:0]};
               end else if (pos_ff >= 5'd12 && pos_ff < 5'd16) begin
                  rate_in = {b, rate_ff[31:8]};
               end else if (pos_ff == 5'd22) begin
                  width_in = {8'd0, b};
               end else if (pos_ff == 5'd23) begin
                  width_in = {b, width_ff[7:0]};
               end
               if (pos_ff >= 5'd23) begin
                  pos_in = '0;
                  fmt_ok = (id_in == whp_pkg::ID_FMT) && (size_in == whp_pkg::FMT_SIZE);
                  if (!fmt_ok) begin
                     phase_in  = whp_pkg::PH_FAILED;
                     status_in = whp_pkg::ST_FAIL;
                  end else begin
                     phase_in = whp_pkg::PH_SEARCH;
                  end
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
            whp_pkg::PH_SEARCH: begin
               if (pos_ff < 5'd4) begin
                  id_in = {id_ff[23:0], b};
               end else begin
                  size_in = {b, size_ff[31:8]};
               end
               if (pos_ff >= 5'd7) begin
                  pos_in = '0;
                  if (id_in == whp_pkg::ID_DATA) begin
                     phase_in  = whp_pkg::PH_PAYLOAD;
                     status_in = whp_pkg::ST_DONE;
                  end else begin
                     skip_in  = size_in;
                     phase_in = (size_in == '0) ? whp_pkg::PH_SEARCH : whp_pkg::PH_SKIP;
                  end
               end else begin
                  pos_in = pos_ff + 5'd1;
               end
            end
            whp_pkg::PH_SKIP: begin
               if (skip_ff != '0) begin
                  skip_in = skip_ff - 32'd1;
               end
               if (skip_ff <= 32'd1) begin
                  phase_in = whp_pkg::PH_SEARCH;
                  pos_in   = '0;
               end
            end
            whp_pkg::PH_PAYLOAD: begin
               status_in = whp_pkg::ST_PAYLOAD;
               pay_in    = b;
            end
            default: begin
               status_in = whp_pkg::ST_IGNORED;
            end
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= whp_pkg::PH_RIFF;
         pos_ff       <= '0;
         id_ff        <= '0;
         size_ff      <= '0;
         skip_ff      <= '0;
         chan_ff      <= '0;
         width_ff     <= '0;
         rate_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            phase_ff <= phase_in;
            pos_ff   <= pos_in;
            id_ff    <= id_in;
            size_ff  <= size_in;
            skip_ff  <= skip_in;
            chan_ff  <= chan_in;
            width_ff <= width_in;
            rate_ff  <= rate_in;
         end
      end
   end

   // result payload; format fields only show on done and payload results
   always_ff @(posedge clock) begin
      if (take) begin
         status_ff <= status_in;
         pay_ff    <= pay_in;
         if (status_in == whp_pkg::ST_DONE || status_in == whp_pkg::ST_PAYLOAD) begin
            out_chan_ff  <= chan_ff;
            out_width_ff <= width_ff;
            out_rate_ff  <= rate_ff;
         end else begin
            out_chan_ff  <= '0;
            out_width_ff <= '0;
            out_rate_ff  <= '0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_payload_byte  = pay_ff;
   assign rsp_channel_count = out_chan_ff;
   assign rsp_sample_width  = out_width_ff;
   assign rsp_rate_hz       = out_rate_ff;

`ifndef SYNTH
   a_fields_gated: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != whp_pkg::ST_DONE && status_ff != whp_pkg::ST_PAYLOAD
      |-> out_chan_ff == '0 && out_width_ff == '0 && out_rate_ff == '0)
      else $error("format fields leak outside done/payload");

   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      take && head.entry.kind == whp_pkg::KIND_RESTART
      |=> phase_ff == whp_pkg::PH_RIFF && pos_ff == '0 && status_ff == whp_pkg::ST_IGNORED)
      else $error("restart did not return to riff phase");

   a_fail_sticks: assert property (@(posedge clock) disable iff (reset)
      take && status_in == whp_pkg::ST_FAIL |=> phase_ff == whp_pkg::PH_FAILED)
      else $error("failure did not enter failed phase");

   a_payload_phase: assert property (@(posedge clock) disable iff (reset)
      take && status_in == whp_pkg::ST_PAYLOAD |-> phase_ff == whp_pkg::PH_PAYLOAD)
      else $error("payload result outside payload phase");

   a_search_pos: assert property (@(posedge clock) disable iff (reset)
      phase_ff == whp_pkg::PH_SEARCH |-> pos_ff <= 5'd7)
      else $error("chunk header position out of range");
`endif

endmodule

/* design/wav_header_parser.sv */
// Top level of the RIFF/WAVE header parser: front queue plus parse back end.
// Depends on whp_pkg, whp_front and whp_back.
//
//   channel | ports                          | direction | moves
//   --------+--------------------------------+-----------+-------------------------
//   req     | req_valid/req_stall, action,   | in        | one stream byte or a
//           | stream_byte                    |           | restart per request
//   rsp     | rsp_valid/rsp_stall, status,   | out       | one result per request
//           | payload_byte, format fields    |           |
//
// One request per cycle sustained while rsp_stall stays low. An accepted request is
// written into the queue; its result is registered when the back end takes it from there.
// The parse state update is one step per byte in the back end, which sets the rate.
// Reset is synchronous: the queue empties, the parser returns to the RIFF header phase.
// req_stall rises only when the queue holds QueueDepth requests; a stalled result
// register stops the back end while the front keeps filling the queue.
module wav_header_parser #(
   parameter int QueueDepth = whp_pkg::QUEUE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [7:0]  req_stream_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_payload_byte,
   output logic [15:0] rsp_channel_count,
   output logic [15:0] rsp_sample_width,
   output logic [31:0] rsp_rate_hz
);

   whp_pkg::head_type head;   // queue head to the back end
   logic              pop;    // back end consumed the head

   // front: accept, tag restarts, queue
   whp_front #(
      .Depth(QueueDepth)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_stream_byte (req_stream_byte),
      .head            (head),
      .pop             (pop)
   );

   // back: header state machine, chunk skipping, registered results
   whp_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (head),
      .pop               (pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_channel_count (rsp_channel_count),
      .rsp_sample_width  (rsp_sample_width),
      .rsp_rate_hz       (rsp_rate_hz)
   );

endmodule

/* verif/tb_wav_header_parser.sv */
// Self-checking testbench for wav_header_parser: directed and random wave-file streams.
// Depends on whp_pkg and the wav_header_parser RTL; standalone, no files or arguments.
module tb_wav_header_parser;
   timeunit 1ns;
   timeprecision 1ps;

   // random part size in requests, and the run's cycle budget
   localparam int RANDOM_REQUESTS = 900;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int PRINT_CAP       = 40;
   localparam int DRAIN_CYCLES    = 8;

   typedef struct {
      whp_pkg::kind_type kind;
      logic [7:0]        data;
   } stream_request_type;

   // one expected result of the parser
   typedef struct {
      whp_pkg::status_type status;
      logic [7:0]          payload;
      logic [15:0]         channels;
      logic [15:0]         width;
      logic [31:0]         rate;
   } parse_result_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_LIGHT,
      STALL_HEAVY,
      STALL_TOGGLE
   } stall_pattern_type;

   // --------------------------------------------------------------------------
   // DUT and its ports; every input holds a known value from time zero
   // --------------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_action = 1'b0;
   logic [7:0]  req_stream_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [7:0]  rsp_payload_byte;
   logic [15:0] rsp_channel_count;
   logic [15:0] rsp_sample_width;
   logic [31:0] rsp_rate_hz;

   wav_header_parser dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_stream_byte   (req_stream_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_payload_byte  (rsp_payload_byte),
      .rsp_channel_count (rsp_channel_count),
      .rsp_sample_width  (rsp_sample_width),
      .rsp_rate_hz       (rsp_rate_hz)
   );

   always #10 clock = ~clock;

   // --------------------------------------------------------------------------
   // Testbench state
   // --------------------------------------------------------------------------
   stream_request_type pending_requests[$];    // stimulus not yet driven
   parse_result_type   expected_results[$];    // predictions awaiting a result

   int mismatch_count = 0;
   int result_count   = 0;
   int file_count     = 0;
   int cycle_count    = 0;
   int done_count     = 0;
   int payload_count  = 0;
   int fail_count     = 0;
   int ignored_count  = 0;

   logic req_taken = 1'b0;   // request accepted at the last rising edge
   logic draining  = 1'b0;   // end of run: receiver stops stalling

   // parser mirror
   whp_pkg::phase_type parse_phase  = whp_pkg::PH_RIFF;
   logic [4:0]         hdr_pos      = '0;
   logic [31:0]        id_word      = '0;
   logic [31:0]        size_word    = '0;
   logic [31:0]        skip_left    = '0;
   logic [15:0]        fmt_channels = '0;
   logic [15:0]        fmt_width    = '0;
   logic [31:0]        fmt_rate     = '0;

   // driver and stall pattern bookkeeping
   stream_request_type next_request;
   int                 burst_left = 0;
   int                 gap_left   = 0;
   stall_pattern_type  stall_mode = STALL_NONE;
   int                 stall_span = 0;
   parse_result_type   head_result;
   parse_result_type   new_result;

   // --------------------------------------------------------------------------
   // Parser prediction: one result per accepted request
   // --------------------------------------------------------------------------
   function automatic void clear_parser();
      parse_phase  = whp_pkg::PH_RIFF;
      hdr_pos      = '0;
      id_word      = '0;
      size_word    = '0;
      skip_left    = '0;
      fmt_channels = '0;
      fmt_width    = '0;
      fmt_rate     = '0;
   endfunction

   function automatic parse_result_type parse_request(whp_pkg::kind_type kind,
                                                      logic [7:0] b);
      parse_result_type r;
      r.status   = whp_pkg::ST_TAKEN;
      r.payload  = '0;
      r.channels = '0;
      r.width    = '0;
      r.rate     = '0;
      if (kind == whp_pkg::KIND_RESTART) begin
         clear_parser();
         r.status = whp_pkg::ST_IGNORED;
      end else begin
         case (parse_phase)
            whp_pkg::PH_RIFF: begin
               // bytes 4..7 (RIFF size) are not looked at; WAVE id lands in size_word
               if (hdr_pos < 5'd4) begin
                  id_word = {id_word[23:0], b};
               end else if (hdr_pos >= 5'd8) begin
                  size_word = {size_word[23:0], b};
               end
               if (hdr_pos >= 5'd11) begin
                  hdr_pos = '0;
                  if (id_word != whp_pkg::ID_RIFF || size_word != whp_pkg::ID_WAVE) begin
                     parse_phase = whp_pkg::PH_FAILED;
                     r.status    = whp_pkg::ST_FAIL;
                  end else begin
                     parse_phase = whp_pkg::PH_FMT;
                  end
               end else begin
                  hdr_pos = hdr_pos + 5'd1;
               end
            end
            whp_pkg::PH_FMT: begin
               if (hdr_pos < 5'd4) begin
                  id_word = {id_word[23:0], b};
               end else if (hdr_pos < 5'd8) begin
                  size_word = {b, size_word[31:8]};
               end else if (hdr_pos == 5'd10) begin
                  fmt_channels = {8'h00, b};
               end else if (hdr_pos == 5'd11) begin
                  fmt_channels[15:8] = b;
               end else if (hdr_pos >= 5'd12 && hdr_pos < 5'd16) begin
                  fmt_rate = {b, fmt_rate[31:8]};
               end else if (hdr_pos == 5'd22) begin
                  fmt_width = {8'h00, b};
               end else if (hdr_pos == 5'd23) begin
                  fmt_width[15:8] = b;
               end
               // id and size are judged on the last fmt byte
               if (hdr_pos >= 5'd23) begin
                  hdr_pos = '0;
                  if (id_word != whp_pkg::ID_FMT || size_word != whp_pkg::FMT_SIZE) begin
                     parse_phase = whp_pkg::PH_FAILED;
                     r.status    = whp_pkg::ST_FAIL;
                  end else begin
                     parse_phase = whp_pkg::PH_SEARCH;
                  end
               end else begin
                  hdr_pos = hdr_pos + 5'd1;
               end
            end
            whp_pkg::PH_SEARCH: begin
               if (hdr_pos < 5'd4) begin
                  id_word = {id_word[23:0], b};
               end else begin
                  size_word = {b, size_word[31:8]};
               end
               if (hdr_pos >= 5'd7) begin
                  hdr_pos = '0;
                  if (id_word == whp_pkg::ID_DATA) begin
                     parse_phase = whp_pkg::PH_PAYLOAD;
                     r.status    = whp_pkg::ST_DONE;
                  end else begin
                     // other chunk: skip its body; an empty chunk goes straight back to the search
                     skip_left   = size_word;
                     parse_phase = (skip_left == 0) ? whp_pkg::PH_SEARCH : whp_pkg::PH_SKIP;
                  end
               end else begin
                  hdr_pos = hdr_pos + 5'd1;
               end
            end
            whp_pkg::PH_SKIP: begin
               if (skip_left != 0) begin
                  skip_left = skip_left - 1;
               end
               if (skip_left == 0) begin
                  parse_phase = whp_pkg::PH_SEARCH;
                  hdr_pos     = '0;
               end
            end
            whp_pkg::PH_PAYLOAD: begin
               r.status  = whp_pkg::ST_PAYLOAD;
               r.payload = b;
            end
            default: begin
               r.status = whp_pkg::ST_IGNORED;
            end
         endcase
      end
      if (r.status == whp_pkg::ST_DONE || r.status == whp_pkg::ST_PAYLOAD) begin
         r.channels = fmt_channels;
         r.width    = fmt_width;
         r.rate     = fmt_rate;
      end
      return r;
   endfunction

   // --------------------------------------------------------------------------
   // Stimulus builders: each call appends requests to the pending queue
   // --------------------------------------------------------------------------
   function automatic void push_byte(logic [7:0] b);
      stream_request_type q;
      q.kind = whp_pkg::KIND_BYTE;
      q.data = b;
      pending_requests.push_back(q);
   endfunction

   function automatic void push_restart();
      stream_request_type q;
      q.kind = whp_pkg::KIND_RESTART;
      q.data = 8'($urandom());   // must be ignored
      pending_requests.push_back(q);
   endfunction

   // chunk ids go out first character first
   function automatic void push_id(logic [31:0] w);
      for (int i = 3; i >= 0; i--) push_byte(w[8*i +: 8]);
   endfunction

   function automatic void push_le(logic [31:0] w, int nbytes);
      for (int i = 0; i < nbytes; i++) push_byte(w[8*i +: 8]);
   endfunction

   function automatic void push_noise(int n);
      for (int i = 0; i < n; i++) push_byte(8'($urandom()));
   endfunction

   // RIFF header plus a 24-byte fmt chunk; format code, byte rate and align are random
   function automatic void append_header(logic [31:0] riff_id, logic [31:0] wave_id,
                                         logic [31:0] fmt_id, logic [31:0] fmt_size,
                                         logic [15:0] channels, logic [31:0] rate,
                                         logic [15:0] width);
      file_count++;
      push_id(riff_id);
      push_le($urandom(), 4);
      push_id(wave_id);
      push_id(fmt_id);
      push_le(fmt_size, 4);
      push_le($urandom(), 2);
      push_le({16'h0, channels}, 2);
      push_le(rate, 4);
      push_le($urandom(), 4);
      push_le($urandom(), 2);
      push_le({16'h0, width}, 2);
   endfunction

   function automatic void append_chunk(logic [31:0] id, logic [31:0] size, int body_len);
      push_id(id);
      push_le(size, 4);
      push_noise(body_len);
   endfunction

   function automatic logic [31:0] random_chunk_id();
      logic [31:0] id;
      do begin
         case ($urandom_range(0, 4))
            0: id = 32'h4C49_5354;   // "LIST"
            1: id = 32'h6661_6374;   // "fact"
            2: id = whp_pkg::ID_FMT;
            3: id = {8'h64, 8'h61, 8'h74, 8'($urandom())};   // near "data"
            default: id = $urandom();
         endcase
      end while (id == whp_pkg::ID_DATA);
      return id;
   endfunction

   function automatic logic [31:0] random_mask();
      logic [31:0] m;
      m = $urandom();
      return (m == 0) ? 32'h1 : m;
   endfunction

   // well-formed file with random format, a few skipped chunks and some payload
   function automatic void append_random_file();
      logic [15:0] channels;
      logic [15:0] width;
      logic [31:0] rate;
      int          size;
      channels = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(1, 8)) : 16'($urandom());
      case ($urandom_range(0, 4))
         0: width = 16'd8;
         1: width = 16'd16;
         2: width = 16'd24;
         3: width = 16'd32;
         default: width = 16'($urandom());
      endcase
      rate = ($urandom_range(0, 1) == 0) ? 32'd44100 + $urandom_range(0, 3900) : $urandom();
      append_header(whp_pkg::ID_RIFF, whp_pkg::ID_WAVE, whp_pkg::ID_FMT, whp_pkg::FMT_SIZE,
                    channels, rate, width);
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 15))
            0, 1, 2, 3, 4: size = 0;
            15:            size = $urandom_range(13, 200);
            default:       size = $urandom_range(1, 12);
         endcase
         append_chunk(random_chunk_id(), size, size);
      end
      append_chunk(whp_pkg::ID_DATA, $urandom(), 0);
      push_noise($urandom_range(0, 24));
   endfunction

   // header with exactly one field broken, then bytes that must be ignored
   function automatic void append_broken_file();
      logic [31:0] riff_id;
      logic [31:0] wave_id;
      logic [31:0] fmt_id;
      logic [31:0] fmt_size;
      riff_id  = whp_pkg::ID_RIFF;
      wave_id  = whp_pkg::ID_WAVE;
      fmt_id   = whp_pkg::ID_FMT;
      fmt_size = whp_pkg::FMT_SIZE;
      case ($urandom_range(0, 3))
         0: riff_id = riff_id ^ random_mask();
         1: wave_id = wave_id ^ random_mask();
         2: fmt_id  = fmt_id ^ random_mask();
         default: fmt_size = fmt_size ^ (($urandom_range(0, 1) == 0) ?
                                         (32'h1 << $urandom_range(0, 31)) : random_mask());
      endcase
      append_header(riff_id, wave_id, fmt_id, fmt_size, 16'($urandom()), $urandom(),
                    16'($urandom()));
      push_noise($urandom_range(0, 6));
   endfunction

   // --------------------------------------------------------------------------
   // Mismatch reporting
   // --------------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < PRINT_CAP) begin
         $display("[%0t] result %0d: %s got 0x%0h, want 0x%0h", $realtime, result_count,
                  what, got, want);
      end
      mismatch_count++;
   endtask

   // --------------------------------------------------------------------------
   // Request driver: bursts of random length with random gaps; a stalled
   // request holds its payload until accepted
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_taken) begin
            // still waiting for acceptance
         end else if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left  = gap_left - 1;
         end else if (pending_requests.size() != 0) begin
            next_request = pending_requests.pop_front();
            req_valid       <= 1'b1;
            req_action      <= next_request.kind;
            req_stream_byte <= next_request.data;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left = burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // --------------------------------------------------------------------------
   // Result stall: pattern switches among none, light, heavy and toggling
   // --------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset || draining) begin
         rsp_stall <= 1'b0;
      end else begin
         if (stall_span == 0) begin
            stall_mode = stall_pattern_type'($urandom_range(0, 3));
            stall_span = $urandom_range(20, 150);
         end else begin
            stall_span = stall_span - 1;
         end
         case (stall_mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 7) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // --------------------------------------------------------------------------
   // Monitor: predict on each accepted request, then check each accepted
   // result against the oldest prediction
   // --------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_valid && !req_stall;
         if (req_valid && !req_stall) begin
            new_result = parse_request(whp_pkg::kind_type'(req_action), req_stream_byte);
            expected_results.push_back(new_result);
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with none expected, status", 32'(rsp_status), '0);
            end else begin
               head_result = expected_results.pop_front();
               if (rsp_status !== head_result.status)
                  report_mismatch("status", 32'(rsp_status), 32'(head_result.status));
               if (rsp_payload_byte !== head_result.payload)
                  report_mismatch("payload_byte", 32'(rsp_payload_byte),
                                  32'(head_result.payload));
               if (rsp_channel_count !== head_result.channels)
                  report_mismatch("channel_count", 32'(rsp_channel_count),
                                  32'(head_result.channels));
               if (rsp_sample_width !== head_result.width)
                  report_mismatch("sample_width", 32'(rsp_sample_width),
                                  32'(head_result.width));
               if (rsp_rate_hz !== head_result.rate)
                  report_mismatch("rate_hz", rsp_rate_hz, head_result.rate);
               case (head_result.status)
                  whp_pkg::ST_DONE:    done_count++;
                  whp_pkg::ST_PAYLOAD: payload_count++;
                  whp_pkg::ST_FAIL:    fail_count++;
                  whp_pkg::ST_IGNORED: ignored_count++;
                  default:             ;
               endcase
            end
            result_count++;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results still expected", cycle_count,
                  expected_results.size());
         $display("Mismatches found");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus plan and end of run
   // --------------------------------------------------------------------------
   initial begin
      int random_target;
      int pick;

      clear_parser();

      // ---- directed ----
      // restart straight out of reset
      push_restart();
      // all-ones format; empty chunk skipped at once, one-byte chunk, empty data
      append_header(whp_pkg::ID_RIFF, whp_pkg::ID_WAVE, whp_pkg::ID_FMT, whp_pkg::FMT_SIZE,
                    16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF);
      append_chunk(32'h4C49_5354, 32'd0, 0);
      append_chunk(random_chunk_id(), 32'd1, 1);
      append_chunk(whp_pkg::ID_DATA, 32'd0, 0);
      push_byte(8'h00);
      push_byte(8'hFF);
      // restart mid-payload, then all-zero format with data at once
      push_restart();
      append_header(whp_pkg::ID_RIFF, whp_pkg::ID_WAVE, whp_pkg::ID_FMT, whp_pkg::FMT_SIZE,
                    16'h0000, 32'h0, 16'h0000);
      append_chunk(whp_pkg::ID_DATA, 32'hFFFF_FFFF, 0);
      push_byte(8'hA5);
      // each header check fails on its last byte; following bytes are ignored
      push_restart();
      append_header(32'h5249_4658, whp_pkg::ID_WAVE, whp_pkg::ID_FMT, whp_pkg::FMT_SIZE,
                    16'd2, 32'd48000, 16'd16);
      push_noise(2);
      push_restart();
      append_header(whp_pkg::ID_RIFF, 32'h5741_5646, whp_pkg::ID_FMT, whp_pkg::FMT_SIZE,
                    16'd1, 32'd8000, 16'd8);
      push_restart();
      append_header(whp_pkg::ID_RIFF, whp_pkg::ID_WAVE, 32'h464D_5420, whp_pkg::FMT_SIZE,
                    16'd1, 32'd8000, 16'd8);
      push_restart();
      append_header(whp_pkg::ID_RIFF, whp_pkg::ID_WAVE, whp_pkg::ID_FMT, 32'd18,
                    16'd1, 32'd8000, 16'd8);
      push_noise(2);
      // restart in the middle of the RIFF header, then a clean file
      push_restart();
      push_id(whp_pkg::ID_RIFF);
      push_noise(2);
      push_restart();
      append_random_file();

      // ---- random ----
      random_target = pending_requests.size() + RANDOM_REQUESTS;
      while (pending_requests.size() < random_target) begin
         pick = $urandom_range(0, 99);
         push_restart();
         if (pick < 68) begin
            append_random_file();
         end else if (pick < 80) begin
            append_broken_file();
         end else if (pick < 88) begin
            // long chunk cut short by the next restart
            append_header(whp_pkg::ID_RIFF, whp_pkg::ID_WAVE, whp_pkg::ID_FMT,
                          whp_pkg::FMT_SIZE, 16'($urandom()), $urandom(),
                          16'($urandom()));
            append_chunk(random_chunk_id(), $urandom() | 32'h100, $urandom_range(0, 10));
         end else if (pick < 94) begin
            // file cut short at its end, in the header or after it
            append_random_file();
            pending_requests = pending_requests[0:$ - $urandom_range(20, 40)];
         end else begin
            // plain noise after a restart, sometimes followed by a second restart
            push_noise($urandom_range(1, 20));
            if ($urandom_range(0, 1) == 0) push_restart();
         end
      end

      // ---- reset and wait for the stream to drain ----
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || req_valid) @(negedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      draining <= 1'b1;
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Checked %0d results from %0d wave headers in %0d cycles", result_count,
               file_count, cycle_count);
      $display("  %0d parses done, %0d payload bytes, %0d failures, %0d ignored",
               done_count, payload_count, fail_count, ignored_count);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* sim.f */
design/whp_pkg.sv
design/whp_front.sv
design/whp_back.sv
design/wav_header_parser.sv
verif/tb_wav_header_parser.sv
